### hdl/lsrp_pkg.sv
// Shared types, codes and the CRC-8 byte update for the level sensor reply parser.
package lsrp_pkg;

  localparam logic [7:0] SOF_BYTE        = 8'h3E;
  localparam logic [7:0] OPC_READING     = 8'h06;
  localparam logic [7:0] OPC_VERSION     = 8'h23;
  localparam logic [7:0] VERSION_SUB     = 8'h00;
  localparam logic [7:0] VERSION_END     = 8'h0A;
  localparam logic [7:0] CRC_POLY        = 8'h8C;
  localparam logic [15:0] LEVEL_LIMIT_RST = 16'd4095;

  localparam int unsigned MAX_VERSION_CHARS = 32;
  localparam int unsigned VCOUNT_W          = 6;
  localparam logic [VCOUNT_W-1:0] VCOUNT_CAP = VCOUNT_W'(MAX_VERSION_CHARS);

  localparam int unsigned TDATA_W = 64;

  typedef enum logic [1:0] {
    KIND_READING     = 2'd0,
    KIND_VERSION_CHR = 2'd1,
    KIND_VERSION_END = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_CRC_ERR  = 2'd1,
    STAT_OVER_LIM = 2'd2
  } status_t;

  typedef struct packed {
    kind_t             kind;
    status_t           status;
    logic [7:0]        sensor_address;
    logic signed [7:0] temperature;
    logic [15:0]       level;
    logic [15:0]       frequency;
    logic [7:0]        version_char;
    logic              last;
  } result_t;

  // Reflected CRC-8 (poly 0x8C), one byte, LSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[0] ^ data[k];
      crc = {1'b0, crc[7:1]};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  localparam logic [7:0] CRC_AFTER_SOF = crc8_byte(8'h00, SOF_BYTE);

endpackage

### hdl/level_sensor_reply_parser.sv
// Top level of the level sensor reply parser: ports, limit register, parser and result queue.
//
// Input stream: one reply byte per item on s_axis_tdata, s_axis_tuser set on the
// first byte of each frame. Frames opening with 0x3E and opcode 0x06 yield one
// reading item (status crc mismatch / level over limit / ok, in that priority);
// opcode 0x23 with sub-byte 0x00 yields one item per version character, the last
// one flagged by m_axis_tlast (0x0A terminator or 32-character cap).
// Config channel: cfg_data writes the 16-bit level limit; always ready.
// Throughput: one input item per cycle while the result queue has room. Each byte
// is parsed and the CRC-8 advanced by one unrolled byte update in the accepting
// cycle; a resulting item is registered into the result queue at the accepting edge.
// Output stall: results sit in a two-entry register (output plus skid slot);
// s_axis_tready is low whenever both entries are full, even in a cycle where
// m_axis drains one, so a stall during back-to-back results costs input cycles.
// Reset (rst, synchronous): parser back to idle, CRC and captured fields to
// zero, level limit to 4095, result queue emptied.
module level_sensor_reply_parser (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [9:2] sensor_address, [17:10] temperature, [33:18] level,
  // [49:34] frequency, [57:50] version_char, [63:58] zero
  output logic [lsrp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,   // last
  // level limit write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import lsrp_pkg::*;

  logic [15:0] level_limit;
  logic        take;
  logic        res_valid;
  result_t     res;
  result_t     out_res;
  logic        has_room;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_limit <= LEVEL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      level_limit <= cfg_data;
    end
  end

  assign s_axis_tready = has_room;
  assign take          = s_axis_tvalid && s_axis_tready;

  lsrp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .rx_byte     (s_axis_tdata),
    .frame_start (s_axis_tuser[0]),
    .level_limit (level_limit),
    .res_valid   (res_valid),
    .res         (res)
  );

  lsrp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_data (res),
    .has_room  (has_room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {6'b0,
                         out_res.version_char,
                         out_res.frequency,
                         out_res.level,
                         out_res.temperature,
                         out_res.sensor_address,
                         out_res.status};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

### hdl/lsrp_parser.sv
// Frame parser: phase tracking, CRC accumulation, field capture and result forming.
module lsrp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       rx_byte,
  input  logic             frame_start,
  input  logic [15:0]      level_limit,
  output logic             res_valid,
  output lsrp_pkg::result_t res
);
  import lsrp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ADDR   = 4'd1,
    PH_OPC    = 4'd2,
    PH_TEMP   = 4'd3,
    PH_LVL_LO = 4'd4,
    PH_LVL_HI = 4'd5,
    PH_FRQ_LO = 4'd6,
    PH_FRQ_HI = 4'd7,
    PH_CRC    = 4'd8,
    PH_VSUB   = 4'd9,
    PH_VCHAR  = 4'd10
  } phase_t;

  phase_t              phase, phase_next;
  logic [7:0]          crc, crc_next;
  logic [7:0]          address, address_next;
  logic [7:0]          temperature, temperature_next;
  logic [15:0]         level, level_next;
  logic [15:0]         frequency, frequency_next;
  logic [VCOUNT_W-1:0] vcount, vcount_next;
  logic [7:0]          crc_upd;
  logic [VCOUNT_W-1:0] vcount_inc;

  assign crc_upd    = crc8_byte(crc, rx_byte);
  assign vcount_inc = vcount + VCOUNT_W'(1);

  always_comb begin
    phase_next       = phase;
    crc_next         = crc;
    address_next     = address;
    temperature_next = temperature;
    level_next       = level;
    frequency_next   = frequency;
    vcount_next      = vcount;
    res_valid        = 1'b0;
    res              = '0;
    res.sensor_address = address;

    if (frame_start) begin
      // a start byte always restarts parsing; only 0x3E opens a new frame
      if (rx_byte == SOF_BYTE) begin
        crc_next   = CRC_AFTER_SOF;
        phase_next = PH_ADDR;
      end else begin
        crc_next   = 8'h00;
        phase_next = PH_IDLE;
      end
    end else begin
      case (phase)
        PH_ADDR: begin
          address_next = rx_byte;
          crc_next     = crc_upd;
          phase_next   = PH_OPC;
        end
        PH_OPC: begin
          crc_next = crc_upd;
          if (rx_byte == OPC_READING) begin
            phase_next = PH_TEMP;
          end else if (rx_byte == OPC_VERSION) begin
            phase_next = PH_VSUB;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_TEMP: begin
          temperature_next = rx_byte;
          crc_next         = crc_upd;
          phase_next       = PH_LVL_LO;
        end
        PH_LVL_LO: begin
          level_next = {8'h00, rx_byte};
          crc_next   = crc_upd;
          phase_next = PH_LVL_HI;
        end
        PH_LVL_HI: begin
          level_next = {rx_byte, level[7:0]};
          crc_next   = crc_upd;
          phase_next = PH_FRQ_LO;
        end
        PH_FRQ_LO: begin
          frequency_next = {8'h00, rx_byte};
          crc_next       = crc_upd;
          phase_next     = PH_FRQ_HI;
        end
        PH_FRQ_HI: begin
          frequency_next = {rx_byte, frequency[7:0]};
          crc_next       = crc_upd;
          phase_next     = PH_CRC;
        end
        PH_CRC: begin
          res_valid       = 1'b1;
          res.kind        = KIND_READING;
          res.temperature = temperature;
          res.level       = level;
          res.frequency   = frequency;
          // CRC check wins over the range check
          if (rx_byte != crc) begin
            res.status = STAT_CRC_ERR;
          end else if (level > level_limit) begin
            res.status = STAT_OVER_LIM;
          end else begin
            res.status = STAT_OK;
          end
          phase_next = PH_IDLE;
        end
        PH_VSUB: begin
          if (rx_byte == VERSION_SUB) begin
            vcount_next = '0;
            phase_next  = PH_VCHAR;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_VCHAR: begin
          res_valid        = 1'b1;
          res.version_char = rx_byte;
          if (rx_byte == VERSION_END) begin
            res.kind   = KIND_VERSION_END;
            res.last   = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            res.kind    = KIND_VERSION_CHR;
            vcount_next = vcount_inc;
            if (vcount_inc >= VCOUNT_CAP) begin
              res.last   = 1'b1;
              phase_next = PH_IDLE;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      crc         <= '0;
      address     <= '0;
      temperature <= '0;
      level       <= '0;
      frequency   <= '0;
      vcount      <= '0;
    end else if (take) begin
      phase       <= phase_next;
      crc         <= crc_next;
      address     <= address_next;
      temperature <= temperature_next;
      level       <= level_next;
      frequency   <= frequency_next;
      vcount      <= vcount_next;
    end
  end

endmodule

### hdl/lsrp_out_queue.sv
// Two-entry result register with skid slot between parser and output channel.
module lsrp_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lsrp_pkg::result_t push_data,
  output logic              has_room,
  output logic              out_valid,
  input  logic              out_ready,
  output lsrp_pkg::result_t out_data
);
  import lsrp_pkg::*;

  logic [1:0] count;
  result_t    head;
  result_t    skid;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_data  = head;
  assign has_room  = (count != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: begin
          if (push) begin
            head  <= push_data;
            count <= 2'd1;
          end
        end
        2'd1: begin
          if (pop && push) begin
            head <= push_data;
          end else if (pop) begin
            count <= 2'd0;
          end else if (push) begin
            skid  <= push_data;
            count <= 2'd2;
          end
        end
        2'd2: begin
          if (pop) begin
            head  <= skid;
            count <= 2'd1;
          end
        end
        default: begin
          count <= 2'd0;
        end
      endcase
    end
  end

endmodule
